// ===== rtl/sfe_pkg.sv =====
package sfe_pkg;

  localparam int LINE_DEPTH   = 4096;
  localparam int ADDR_BITS    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int FRAMES_BITS  = ADDR_BITS + 1;
  localparam int SAMPLE_BITS  = 24;
  localparam int LINE_WIDTH   = 2 * SAMPLE_BITS;

  localparam int DELAY_BITS   = 12;
  localparam int MIX_BITS     = 17;
  localparam int FB_BITS      = 16;
  localparam int GAIN_BITS    = 18;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 17;

  // gain * sample, with one sign bit for the unsigned gain
  localparam int PROD_BITS    = GAIN_BITS + 1 + SAMPLE_BITS;
  localparam int FRAC_BITS    = 16;
  localparam int SCALED_BITS  = PROD_BITS - FRAC_BITS;
  localparam int SUM_BITS     = SCALED_BITS + 1;

  localparam logic [MIX_BITS-1:0] MIX_MAX   = 17'd65536;  // 1.0 in Q1.16
  localparam logic [FB_BITS-1:0]  FB_MAX    = 16'd62259;  // 0.95 in Q0.16
  localparam logic [MIX_BITS-1:0] FB_UNITY  = 17'd65536;
  localparam int                  ROUND_HALF = 32768;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DELAY    = 2'd0,
    REG_MIX      = 2'd1,
    REG_FEEDBACK = 2'd2
  } reg_idx_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [ADDR_BITS-1:0]          addr_t;
  typedef logic [GAIN_BITS-1:0]          gain_t;

  typedef struct packed {
    addr_t delay;   // clamped to the line length
    gain_t gain;    // unsigned Q2.16
  } cfg_t;

  typedef struct packed {
    logic accept;    // input item taken this cycle
    logic adv;       // pipeline moves this cycle
    logic use_echo;  // incoming item adds the delayed output
    logic fwd;       // entry read now is the one written now
  } ctrl_t;

endpackage

// ===== rtl/sfe_channels.sv =====
interface sfe_in_if import sfe_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t left_in;
  sample_t right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface sfe_out_if import sfe_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t left_out;
  sample_t right_out;
  logic    clipped;

  modport source (output valid, output left_out, output right_out, output clipped,
                  input ready);
  modport sink   (input valid, input left_out, input right_out, input clipped,
                  output ready);
endinterface

interface sfe_cfg_if import sfe_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/sfe_ram.sv =====
module sfe_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read-first: a read of the entry written at the same edge returns old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sfe_cfg.sv =====
module sfe_cfg import sfe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  sfe_cfg_if.sink   cfg_ch,
  output cfg_t      cfg
);

  logic [DELAY_BITS-1:0] delay_r;
  logic [MIX_BITS-1:0]   mix_r;
  logic [FB_BITS-1:0]    fb_r;
  gain_t                 gain_r;
  gain_t                 gain_nxt;
  logic [MIX_BITS-1:0]   mix_c;
  logic [FB_BITS-1:0]    fb_c;
  logic [MIX_BITS-1:0]   fb_sum;
  logic [2*MIX_BITS-1:0] gprod;
  logic                  wr;

  assign cfg_ch.ready = 1'b1;
  assign wr = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= '0;
      mix_r   <= '0;
      fb_r    <= '0;
    end else if (wr) begin
      unique case (reg_idx_t'(cfg_ch.index))
        REG_DELAY:    delay_r <= cfg_ch.data[DELAY_BITS-1:0];
        REG_MIX:      mix_r   <= cfg_ch.data[MIX_BITS-1:0];
        REG_FEEDBACK: fb_r    <= cfg_ch.data[FB_BITS-1:0];
        default: ;
      endcase
    end
  end

  // gain = mix * (1 + feedback), rounded to Q2.16
  always_comb begin
    mix_c    = (mix_r > MIX_MAX) ? MIX_MAX : mix_r;
    fb_c     = (fb_r > FB_MAX) ? FB_MAX : fb_r;
    fb_sum   = FB_UNITY + MIX_BITS'(fb_c);
    gprod    = (2*MIX_BITS)'(mix_c) * (2*MIX_BITS)'(fb_sum);
    gain_nxt = GAIN_BITS'((gprod + (2*MIX_BITS)'(ROUND_HALF)) >> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0;
    end else begin
      gain_r <= gain_nxt;
    end
  end

  always_comb begin
    if (32'(delay_r) >= LINE_DEPTH) begin
      cfg.delay = ADDR_BITS'(LINE_DEPTH - 1);
    end else begin
      cfg.delay = ADDR_BITS'(delay_r);
    end
    cfg.gain = gain_r;
  end

endmodule

// ===== rtl/sfe_ctrl.sv =====
module sfe_ctrl import sfe_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  logic   out_ready,
  output logic   out_valid,
  input  addr_t  delay,
  output ctrl_t  ctl,
  output logic   ram_re,
  output addr_t  ram_raddr,
  output logic   ram_we,
  output addr_t  ram_waddr
);

  localparam logic [FRAMES_BITS-1:0] DEPTH_W = FRAMES_BITS'(LINE_DEPTH);

  addr_t                  wp_r;
  addr_t                  wp_nxt;
  logic [FRAMES_BITS-1:0] frames_r;
  addr_t                  s1_addr_r;
  addr_t                  s2_addr_r;
  logic                   s1_valid_r;
  logic                   s2_valid_r;
  logic                   out_valid_r;
  addr_t                  rd_addr;
  logic                   adv;
  logic                   use_echo;
  logic                   hazard;
  logic                   accept;

  assign adv      = !out_valid_r || out_ready;
  assign use_echo = (delay != '0) && (frames_r >= {1'b0, delay});

  always_comb begin
    if (wp_r >= delay) begin
      rd_addr = wp_r - delay;
    end else begin
      rd_addr = ADDR_BITS'({1'b0, wp_r} + DEPTH_W - {1'b0, delay});
    end
    wp_nxt = (32'(wp_r) == LINE_DEPTH - 1) ? '0 : wp_r + 1'b1;
  end

  // entry still in the multiply stage: its value is not written yet
  assign hazard   = use_echo && s1_valid_r && (s1_addr_r == rd_addr);
  assign in_ready = adv && !hazard;
  assign accept   = in_valid && in_ready;

  assign ctl.accept   = accept;
  assign ctl.adv      = adv;
  assign ctl.use_echo = use_echo;
  assign ctl.fwd      = s2_valid_r && (s2_addr_r == rd_addr);

  assign ram_re    = accept;
  assign ram_raddr = rd_addr;
  assign ram_we    = adv && s2_valid_r;
  assign ram_waddr = s2_addr_r;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      frames_r    <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        wp_r <= wp_nxt;
        if (frames_r < DEPTH_W) begin
          frames_r <= frames_r + 1'b1;
        end
      end
      if (adv) begin
        s1_valid_r  <= accept;
        s2_valid_r  <= s1_valid_r;
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r <= wp_r;
    end
    if (adv) begin
      s2_addr_r <= s1_addr_r;
    end
  end

endmodule

// ===== rtl/sfe_dp.sv =====
module sfe_dp import sfe_pkg::*; (
  input  logic                  clk,
  input  ctrl_t                 ctl,
  input  gain_t                 gain,
  input  sample_t               left_in,
  input  sample_t               right_in,
  input  logic [LINE_WIDTH-1:0] ram_rdata,
  output logic [LINE_WIDTH-1:0] ram_wdata,
  output sample_t               left_out,
  output sample_t               right_out,
  output logic                  clipped
);

  // {clip, value}
  function automatic logic [SAMPLE_BITS:0] sat(input logic signed [SUM_BITS-1:0] v);
    logic same;
    same = (v[SUM_BITS-1:SAMPLE_BITS-1] == '0) || (v[SUM_BITS-1:SAMPLE_BITS-1] == '1);
    if (same) begin
      sat = {1'b0, v[SAMPLE_BITS-1:0]};
    end else if (v[SUM_BITS-1]) begin
      sat = {1'b1, 1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      sat = {1'b1, 1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

  // stage 1: delayed sample times gain
  sample_t               s1_xl_r, s1_xr_r;
  logic                  s1_echo_r;
  logic                  s1_fwd_r;
  logic [LINE_WIDTH-1:0] s1_fwd_data_r;
  logic [LINE_WIDTH-1:0] delayed;
  sample_t               dl, dr;
  logic signed [PROD_BITS-1:0] prod_l, prod_r;

  // stage 2: round, add, saturate
  sample_t               s2_xl_r, s2_xr_r;
  logic                  s2_echo_r;
  logic signed [PROD_BITS-1:0]   s2_prod_l_r, s2_prod_r_r;
  logic signed [PROD_BITS-1:0]   rnd_l, rnd_r;
  logic signed [SCALED_BITS-1:0] w_l, w_r;
  logic signed [SUM_BITS-1:0]    sum_l, sum_r;
  logic [SAMPLE_BITS:0]          sat_l, sat_r;
  sample_t               y_l, y_r;
  logic                  clip;

  sample_t               out_l_r, out_r_r;
  logic                  out_clip_r;

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      s1_xl_r       <= left_in;
      s1_xr_r       <= right_in;
      s1_echo_r     <= ctl.use_echo;
      s1_fwd_r      <= ctl.fwd;
      s1_fwd_data_r <= ram_wdata;
    end
  end

  assign delayed = s1_fwd_r ? s1_fwd_data_r : ram_rdata;
  assign dl      = delayed[LINE_WIDTH-1:SAMPLE_BITS];
  assign dr      = delayed[SAMPLE_BITS-1:0];
  assign prod_l  = $signed({1'b0, gain}) * dl;
  assign prod_r  = $signed({1'b0, gain}) * dr;

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      s2_xl_r     <= s1_xl_r;
      s2_xr_r     <= s1_xr_r;
      s2_echo_r   <= s1_echo_r;
      s2_prod_l_r <= prod_l;
      s2_prod_r_r <= prod_r;
    end
  end

  // floor((p + half) / 2^16) is an arithmetic shift after the rounding add
  always_comb begin
    rnd_l = s2_prod_l_r + PROD_BITS'(ROUND_HALF);
    rnd_r = s2_prod_r_r + PROD_BITS'(ROUND_HALF);
    w_l   = rnd_l[PROD_BITS-1:FRAC_BITS];
    w_r   = rnd_r[PROD_BITS-1:FRAC_BITS];
    sum_l = SUM_BITS'(w_l) + SUM_BITS'(s2_xl_r);
    sum_r = SUM_BITS'(w_r) + SUM_BITS'(s2_xr_r);
    sat_l = sat(sum_l);
    sat_r = sat(sum_r);
    if (s2_echo_r) begin
      y_l  = sat_l[SAMPLE_BITS-1:0];
      y_r  = sat_r[SAMPLE_BITS-1:0];
      clip = sat_l[SAMPLE_BITS] || sat_r[SAMPLE_BITS];
    end else begin
      y_l  = s2_xl_r;
      y_r  = s2_xr_r;
      clip = 1'b0;
    end
  end

  assign ram_wdata = {y_l, y_r};

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      out_l_r    <= y_l;
      out_r_r    <= y_r;
      out_clip_r <= clip;
    end
  end

  assign left_out  = out_l_r;
  assign right_out = out_r_r;
  assign clipped   = out_clip_r;

endmodule

// ===== rtl/stereo_feedback_echo_unit.sv =====
// Stereo feedback echo: y = x + gain * y[n - delay] per channel, saturated
// to 24 bits; the saturated output is what goes back into the echo line.
//
// Channels: in_ch takes one stereo frame (left_in, right_in) per item;
// out_ch returns left_out, right_out and a clipped flag per item, in order.
// cfg_ch writes delay_frames (0), mix_gain (1) and feedback_gain (2); it is
// always ready. Write it only while no item is in flight. The echo gain
// is rebuilt in its own register from the registered settings after a write.
//
// Pipeline: an accepted frame passes the line read, the multiply and the
// add/saturate into the output register, one stage each, before out_ch.valid.
// Throughput: one frame per cycle while out_ch is ready. With a delay of one
// frame the echo line entry is still in the multiply stage when the next
// frame wants it, so that frame is held off until the entry moves on.
// The echo line is a single 4096 x 48 RAM, one read and one write per frame;
// a read of the entry written at the same edge is forwarded.
//
// Reset clears config, gain, write pointer, frame count and valid bits.
// Line entries are never used before they are written, so the RAM is not cleared.
// When out_ch stalls, the whole pipe holds and in_ch.ready drops.
module stereo_feedback_echo_unit import sfe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  sfe_in_if.sink    in_ch,
  sfe_out_if.source out_ch,
  sfe_cfg_if.sink   cfg_ch
);

  cfg_t                  cfg;
  ctrl_t                 ctl;
  logic                  ram_re;
  logic                  ram_we;
  addr_t                 ram_raddr;
  addr_t                 ram_waddr;
  logic [LINE_WIDTH-1:0] ram_rdata;
  logic [LINE_WIDTH-1:0] ram_wdata;

  // register file and gain formation
  sfe_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // pointers, frame count, valid pipeline, hazard check
  sfe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .delay     (cfg.delay),
    .ctl       (ctl),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr)
  );

  // echo line: both channels of a frame in one word, left in the upper half
  sfe_ram #(
    .WIDTH (LINE_WIDTH),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // multiply, round, add, saturate, output register
  sfe_dp u_dp (
    .clk       (clk),
    .ctl       (ctl),
    .gain      (cfg.gain),
    .left_in   (in_ch.left_in),
    .right_in  (in_ch.right_in),
    .ram_rdata (ram_rdata),
    .ram_wdata (ram_wdata),
    .left_out  (out_ch.left_out),
    .right_out (out_ch.right_out),
    .clipped   (out_ch.clipped)
  );

endmodule

// ===== sim/tb_stereo_feedback_echo_unit.sv =====
`timescale 1ns / 100ps

module tb_stereo_feedback_echo_unit;
  import sfe_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 12;
  localparam int RANDOM_FRAMES  = 1750;
  localparam int FIXED_SETTINGS = 9;
  localparam int FIXED_FRAMES   = 150;
  // 3-stage pipe plus the gain register rebuild after a write
  localparam int PIPE_SLACK     = 4;
  localparam int DRAIN_LIMIT    = 5000;
  // ~1800 frames at worst-case input gap, output stall and delay-1 hold-off
  localparam int TIMEOUT_CYCLES = 400_000;

  // index the block has no register for; a write there must change nothing
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    sample_t left;
    sample_t right;
    logic    clipped;
  } echo_frame_t;

  // per-item gap policy for either side
  typedef enum int {PACE_FULL, PACE_LAZY, PACE_BURSTY} pace_t;

  // sample flavors for random frames
  typedef enum int {SHAPE_FULL, SHAPE_SOFT, SHAPE_EDGE, SHAPE_QUIET, SHAPE_LOUD} shape_t;

  // Comb-filter predictor plus the queue of frames still owed by the block.
  class echo_scoreboard;
    sample_t               line_l [LINE_DEPTH];
    sample_t               line_r [LINE_DEPTH];
    int unsigned           frames_seen;
    int unsigned           wr_ptr;
    logic [DELAY_BITS-1:0] delay;
    logic [MIX_BITS-1:0]   mix;
    logic [FB_BITS-1:0]    feedback;
    longint                gain;
    echo_frame_t           expected_q [$];
    int                    errors;
    int                    frames_in;
    int                    frames_out;
    int                    clip_count;
    int                    echoed;

    function new();
      frames_seen = 0;
      wr_ptr      = 0;
      delay       = '0;
      mix         = '0;
      feedback    = '0;
      gain        = 0;
      errors      = 0;
      frames_in   = 0;
      frames_out  = 0;
      clip_count  = 0;
      echoed      = 0;
    endfunction

    function void note_config(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      longint m;
      longint f;
      case (idx)
        REG_DELAY:    delay    = data[DELAY_BITS-1:0];
        REG_MIX:      mix      = data[MIX_BITS-1:0];
        REG_FEEDBACK: feedback = data[FB_BITS-1:0];
        default:      return;
      endcase
      m = (mix > MIX_MAX) ? MIX_MAX : mix;
      f = (feedback > FB_MAX) ? FB_MAX : feedback;
      gain = (m * (longint'(FB_UNITY) + f) + ROUND_HALF) >>> FRAC_BITS;
    endfunction

    // gain * delayed sample, rounded half up (arithmetic shift floors)
    function longint echo_term(sample_t past);
      longint p;
      p = gain * longint'(past) + ROUND_HALF;
      return p >>> FRAC_BITS;
    endfunction

    function sample_t saturate(longint v, inout logic hit);
      if (v > longint'(SAMPLE_MAX)) begin
        hit = 1'b1;
        return SAMPLE_MAX;
      end
      if (v < longint'(SAMPLE_MIN)) begin
        hit = 1'b1;
        return SAMPLE_MIN;
      end
      return sample_t'(v);
    endfunction

    function void note_frame(sample_t xl, sample_t xr);
      echo_frame_t e;
      int unsigned rd;
      logic        clip;
      clip = 1'b0;
      if (delay != 0 && frames_seen >= delay) begin
        rd      = (wr_ptr + LINE_DEPTH - delay) % LINE_DEPTH;
        e.left  = saturate(longint'(xl) + echo_term(line_l[rd]), clip);
        e.right = saturate(longint'(xr) + echo_term(line_r[rd]), clip);
        echoed++;
      end else begin
        e.left  = xl;
        e.right = xr;
      end
      e.clipped = clip;
      // saturated output is what feeds back, passthrough frames included
      line_l[wr_ptr] = e.left;
      line_r[wr_ptr] = e.right;
      wr_ptr = (wr_ptr + 1) % LINE_DEPTH;
      if (frames_seen < LINE_DEPTH) frames_seen++;
      expected_q = {expected_q, e};
      frames_in++;
    endfunction

    function void check_result(sample_t l, sample_t r, logic c);
      echo_frame_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected item: left_out %0d right_out %0d clipped %0b", l, r, c);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      frames_out++;
      if (e.clipped) clip_count++;
      if (l !== e.left) begin
        $error("left_out mismatch: expected %0d, got %0d", e.left, l);
        errors++;
      end
      if (r !== e.right) begin
        $error("right_out mismatch: expected %0d, got %0d", e.right, r);
        errors++;
      end
      if (c !== e.clipped) begin
        $error("clipped mismatch: expected %0b, got %0b", e.clipped, c);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  sfe_in_if  in_ch ();
  sfe_out_if out_ch ();
  sfe_cfg_if cfg_ch ();

  echo_scoreboard sb;
  pace_t          in_pace  = PACE_FULL;
  pace_t          out_pace = PACE_FULL;
  int             settings_count = 0;

  stereo_feedback_echo_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Everything is driven with NBAs at the edge, so this sees pre-edge values.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.note_config(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) sb.note_frame(in_ch.left_in, in_ch.right_in);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.left_out, out_ch.right_out, out_ch.clipped);
    end
  end

  function automatic int draw_gap(pace_t p);
    case (p)
      PACE_FULL: return 0;
      PACE_LAZY: return $urandom_range(0, 14);
      default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
    endcase
  endfunction

  function automatic pace_t draw_pace();
    return pace_t'($urandom_range(0, 2));
  endfunction

  function automatic shape_t draw_shape();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return SHAPE_FULL;
    if (roll == 5) return SHAPE_SOFT;
    if (roll == 6) return SHAPE_EDGE;
    if (roll == 7) return SHAPE_QUIET;
    return SHAPE_LOUD;
  endfunction

  function automatic sample_t pick_sample(shape_t s);
    int mag;
    case (s)
      SHAPE_FULL: return sample_t'($urandom);
      SHAPE_SOFT: return sample_t'(int'($urandom_range(0, 8191)) - 4096);
      SHAPE_EDGE: begin
        case ($urandom_range(0, 3))
          0:       return SAMPLE_MAX;
          1:       return SAMPLE_MIN;
          2:       return sample_t'(0);
          default: return sample_t'(-1);
        endcase
      end
      SHAPE_LOUD: begin
        mag = $urandom_range(6000000, 8388607);
        return ($urandom_range(0, 1) != 0) ? sample_t'(mag) : sample_t'(-mag);
      end
      default: return sample_t'(0);
    endcase
  endfunction

  // Valid stays high across back-to-back items; it only drops for a gap.
  task automatic push_frame(input sample_t l, input sample_t r);
    int gap;
    gap = draw_gap(in_pace);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.left_in  <= l;
    in_ch.right_in <= r;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Wait for every owed item, then let the pipe go quiet.
  task automatic wait_drained();
    int guard;
    in_ch.valid <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (sb.pending() != 0 && guard < DRAIN_LIMIT);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  // Writes all three registers back to back, then optionally the spare index; unused upper data bits carry junk.
  task automatic load_settings(input logic [DELAY_BITS-1:0] dly,
                               input logic [MIX_BITS-1:0]   mx,
                               input logic [FB_BITS-1:0]    fb,
                               input bit                    spare);
    logic [CFG_IDX_BITS-1:0]  idx [4];
    logic [CFG_DATA_BITS-1:0] val [4];
    logic [31:0]              junk;
    int                       cnt;
    junk   = $urandom;
    idx[0] = REG_DELAY;
    val[0] = {junk[4:0], dly};
    idx[1] = REG_MIX;
    val[1] = mx;
    idx[2] = REG_FEEDBACK;
    val[2] = {junk[5], fb};
    cnt    = 3;
    if (spare) begin
      idx[3] = CFG_SPARE;
      val[3] = junk[22:6];
      cnt    = 4;
    end
    cfg_ch.valid <= 1'b1;
    for (int i = 0; i < cnt; i++) begin
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= val[i];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    // gain register is rebuilt from the registered settings after the write
    repeat (PIPE_SLACK) @(posedge clk);
    settings_count++;
  endtask

  // Result side: random stall before each item, ready held until it is taken.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = draw_gap(out_pace);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int                    phase;
    int                    rand_frames;
    int                    n;
    shape_t                s;
    logic [DELAY_BITS-1:0] dly;
    logic [MIX_BITS-1:0]   mx;
    logic [FB_BITS-1:0]    fb;
    bit                    spare;

    sb = new();
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.left_in   <= '0;
    in_ch.right_in  <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= REG_DELAY;
    cfg_ch.data     <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset config: zero delay, so everything passes straight through.
    push_frame(SAMPLE_MAX, SAMPLE_MIN);
    push_frame(SAMPLE_MIN, SAMPLE_MAX);
    push_frame(sample_t'(0), sample_t'(0));
    push_frame(sample_t'(-1), sample_t'(1));
    push_frame(sample_t'(24'h555555), sample_t'(24'hAAAAAA));
    push_frame(sample_t'(24'hAAAAAA), sample_t'(24'h555555));
    push_frame(sample_t'(1), sample_t'(-1));
    push_frame(SAMPLE_MAX, SAMPLE_MAX);
    wait_drained();

    // One-frame echo at full gain: clips both ways, then a tail that grows
    // and stays clipped, through the forwarding path.
    load_settings(12'd1, MIX_MAX, FB_MAX, 1'b0);
    push_frame(SAMPLE_MAX, SAMPLE_MIN);
    push_frame(SAMPLE_MAX, SAMPLE_MIN);
    push_frame(SAMPLE_MIN, SAMPLE_MAX);
    push_frame(SAMPLE_MIN, SAMPLE_MIN);
    repeat (4) push_frame(sample_t'(0), sample_t'(0));
    push_frame(sample_t'(1000), sample_t'(-1000));
    repeat (3) push_frame(sample_t'(0), sample_t'(0));

    phase       = 0;
    rand_frames = 0;
    while (rand_frames < RANDOM_FRAMES) begin
      wait_drained();
      case (phase)
        0:       begin dly = 12'd0;    mx = MIX_MAX;    fb = FB_MAX;   end
        1:       begin dly = 12'd1;    mx = 17'd32768;  fb = 16'd0;    end
        2:       begin dly = 12'd2;    mx = MIX_MAX;    fb = FB_MAX;   end
        // echo switches on partway through this one
        3:       begin dly = 12'd560;  mx = 17'd49152;  fb = 16'd30000; end
        4:       begin dly = 12'd3;    mx = 17'd0;      fb = 16'd40000; end
        5:       begin dly = 12'd4095; mx = MIX_MAX;    fb = FB_MAX;   end
        // both gains above their clamp points
        6:       begin dly = 12'd17;   mx = 17'h1FFFF;  fb = 16'hFFFF; end
        7:       begin dly = 12'd100;  mx = 17'd1;      fb = 16'd1;    end
        8:       begin dly = 12'd1;    mx = MIX_MAX;    fb = 16'hFFFF; end
        default: begin
          dly = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                            : 12'($urandom_range(1, 48));
          mx  = ($urandom_range(0, 4) == 0) ? 17'($urandom_range(65537, 131071))
                                            : 17'($urandom_range(0, 65536));
          fb  = 16'($urandom);
        end
      endcase
      spare    = (phase == 6) || ($urandom_range(0, 3) == 0);
      // first setting runs with no idling on either side
      in_pace  = (phase == 0) ? PACE_FULL : draw_pace();
      out_pace = (phase == 0) ? PACE_FULL : draw_pace();
      load_settings(dly, mx, fb, spare);

      n = (phase < FIXED_SETTINGS) ? FIXED_FRAMES : $urandom_range(60, 200);
      repeat (n) begin
        s = draw_shape();
        push_frame(pick_sample(s), pick_sample(s));
      end
      rand_frames += n;
      phase++;
    end

    wait_drained();
    if (sb.pending() != 0) begin
      $error("%0d expected items never came out", sb.pending());
      sb.errors++;
    end

    $display("Covered %0d frames under %0d register settings, %0d of them saturated.",
             sb.frames_out, settings_count, sb.clip_count);
    $display("%0d frames went through the echo path, %0d passed straight through.",
             sb.echoed, sb.frames_in - sb.echoed);
    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
